### sv/tccu_pkg.sv
// ----------------------------------------------------------------------------
// Text console cursor engine package
// Shared types, character codes and glyph codes for the cursor engine.
// ----------------------------------------------------------------------------
package tccu_pkg;

  // Widths of the result position fields and of the cursor state.
  localparam int POS_X_W = 11;
  localparam int POS_Y_W = 10;

  // Width of the internal position arithmetic. It covers a cursor position
  // plus the largest tab advance and the largest supported screen size.
  localparam int CALC_W = 14;

  // Command sequencer step counter width (at most five commands a request).
  localparam int STEP_W = 3;

  typedef logic [POS_X_W-1:0] pos_x_t;
  typedef logic [POS_Y_W-1:0] pos_y_t;
  typedef logic [CALC_W-1:0]  calc_t;
  typedef logic [STEP_W-1:0]  step_t;
  typedef logic [31:0]        colour_t;

  // Configuration register indexes.
  localparam logic REG_FG_COLOUR = 1'b0;
  localparam logic REG_BG_COLOUR = 1'b1;

  // Request types on the input side.
  localparam logic REQ_PUT   = 1'b0;
  localparam logic REQ_CLEAR = 1'b1;

  // Command kinds on the result side.
  localparam logic KIND_GLYPH = 1'b0;
  localparam logic KIND_FILL  = 1'b1;

  // Control characters with special handling.
  localparam logic [7:0] CHAR_BACKSPACE = 8'd8;
  localparam logic [7:0] CHAR_TAB       = 8'd9;
  localparam logic [7:0] CHAR_NEWLINE   = 8'd10;
  localparam logic [7:0] CHAR_RETURN    = 8'd13;

  // Glyph codes used by the engine itself.
  localparam logic [7:0] GLYPH_NONE   = 8'd0;
  localparam logic [7:0] GLYPH_ERASE  = 8'd8;
  localparam logic [7:0] GLYPH_SPACE  = 8'd32;
  localparam logic [7:0] GLYPH_CURSOR = 8'd95;

  // Reset values of the colour registers.
  localparam colour_t FG_COLOUR_RESET = 32'hFFFF_FFFF;
  localparam colour_t BG_COLOUR_RESET = 32'h0000_0000;

  // Request class decided by the front end.
  typedef enum logic [2:0] {
    OP_CLEAR,
    OP_NEWLINE,
    OP_BACKSPACE,
    OP_TAB,
    OP_RETURN,
    OP_PRINT
  } op_e;

  // Classified request word passed from front to back.
  typedef struct packed {
    op_e        op;
    logic [7:0] char_code;
  } req_t;

  // One draw command word.
  typedef struct packed {
    logic    kind;
    pos_x_t  pos_x;
    pos_y_t  pos_y;
    logic [7:0] glyph;
    colour_t colour;
    logic    last;
  } cmd_t;

  // Remainder of an 11-bit column by five. Since 16 is 1 modulo 5, the
  // nibble sum keeps the remainder; a second fold and a short compare chain
  // finish the reduction.
  function automatic logic [2:0] mod5_x(input pos_x_t x);
    logic [5:0] nib_sum;
    logic [4:0] fold;
    nib_sum = 6'(x[3:0]) + 6'(x[7:4]) + 6'(x[10:8]);
    fold    = 5'(nib_sum[3:0]) + 5'(nib_sum[5:4]);
    if (fold >= 5'd15) begin
      fold = fold - 5'd15;
    end else if (fold >= 5'd10) begin
      fold = fold - 5'd10;
    end else if (fold >= 5'd5) begin
      fold = fold - 5'd5;
    end
    return fold[2:0];
  endfunction

endpackage

### sv/text_console_cursor_engine_unit.sv
// ----------------------------------------------------------------------------
// Text console cursor engine
// Turns character and clear-screen requests into glyph draw and screen fill
// commands while tracking a pixel cursor.
//
//   Channel   Handshake            Word
//   request   push / full          req_type_i, char_code_i
//   result    empty / pop          cmd_kind_o, pos_x_o, pos_y_o, glyph_o,
//                                  draw_colour_o, last_cmd_o
//   config    valid / ready        cfg_index_i, cfg_data_i
//
// A request produces one command for a clear, two for carriage return,
// three for newline and printable characters, four for tab and five for
// backspace. The command sequencer sets these figures.
// The front takes a new request word every cycle while its two-entry queue
// has room. Reset homes the cursor, loads the default colours and empties
// both queues. A stalled result queue halts the sequencer, which then fills
// the request queue and raises full.
// ----------------------------------------------------------------------------
module text_console_cursor_engine_unit #(
  parameter int CELL_WIDTH        = 8,
  parameter int CELL_HEIGHT       = 8,
  parameter int SCREEN_PIX_WIDTH  = 1024,
  parameter int SCREEN_PIX_HEIGHT = 768
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Request side.
  input  logic        push,
  output logic        full,
  input  logic        req_type_i,
  input  logic [7:0]  char_code_i,
  // Result side.
  output logic        empty,
  input  logic        pop,
  output logic        cmd_kind_o,
  output logic [10:0] pos_x_o,
  output logic [9:0]  pos_y_o,
  output logic [7:0]  glyph_o,
  output logic [31:0] draw_colour_o,
  output logic        last_cmd_o,
  // Configuration side.
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic        cfg_index_i,
  input  logic [31:0] cfg_data_i
);

  tccu_pkg::colour_t fg_colour_q, fg_colour_d;
  tccu_pkg::colour_t bg_colour_q, bg_colour_d;
  logic              head_valid;
  tccu_pkg::req_t    head;
  logic              head_pop;
  logic              cmd_valid;
  logic              cmd_ready;
  tccu_pkg::cmd_t    cmd;
  tccu_pkg::cmd_t    res;

  // Colour registers, always writable.
  assign cfg_ready_o = 1'b1;

  always_comb begin
    fg_colour_d = fg_colour_q;
    bg_colour_d = bg_colour_q;
    if (cfg_valid_i) begin
      unique case (cfg_index_i)
        tccu_pkg::REG_FG_COLOUR: fg_colour_d = cfg_data_i;
        tccu_pkg::REG_BG_COLOUR: bg_colour_d = cfg_data_i;
        default:                 fg_colour_d = fg_colour_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fg_colour_q <= tccu_pkg::FG_COLOUR_RESET;
      bg_colour_q <= tccu_pkg::BG_COLOUR_RESET;
    end else begin
      fg_colour_q <= fg_colour_d;
      bg_colour_q <= bg_colour_d;
    end
  end

  // Front end: classify and queue requests.
  tccu_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push         (push),
    .full         (full),
    .req_type_i   (req_type_i),
    .char_code_i  (char_code_i),
    .head_valid_o (head_valid),
    .head_o       (head),
    .head_pop_i   (head_pop)
  );

  // Back end: cursor tracking and command sequencing.
  tccu_back #(
    .CELL_WIDTH        (CELL_WIDTH),
    .CELL_HEIGHT       (CELL_HEIGHT),
    .SCREEN_PIX_WIDTH  (SCREEN_PIX_WIDTH),
    .SCREEN_PIX_HEIGHT (SCREEN_PIX_HEIGHT)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_valid_i (head_valid),
    .head_i       (head),
    .head_pop_o   (head_pop),
    .fg_colour_i  (fg_colour_q),
    .bg_colour_i  (bg_colour_q),
    .cmd_valid_o  (cmd_valid),
    .cmd_o        (cmd),
    .cmd_ready_i  (cmd_ready)
  );

  // Result queue toward the consumer.
  tccu_out_fifo u_out_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_valid_i (cmd_valid),
    .wr_data_i  (cmd),
    .wr_ready_o (cmd_ready),
    .empty      (empty),
    .rd_data_o  (res),
    .pop        (pop)
  );

  assign cmd_kind_o    = res.kind;
  assign pos_x_o       = res.pos_x;
  assign pos_y_o       = res.pos_y;
  assign glyph_o       = res.glyph;
  assign draw_colour_o = res.colour;
  assign last_cmd_o    = res.last;

endmodule

### sv/tccu_front.sv
// ----------------------------------------------------------------------------
// Cursor engine front end
// Accepts request words, classifies them and holds them in a two-entry
// queue until the back end has issued all of their commands.
// ----------------------------------------------------------------------------
module tccu_front (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push,
  output logic             full,
  input  logic             req_type_i,
  input  logic [7:0]       char_code_i,
  output logic             head_valid_o,
  output tccu_pkg::req_t   head_o,
  input  logic             head_pop_i
);

  tccu_pkg::req_t mem_q [2];
  logic           wr_ptr_q, wr_ptr_d;
  logic           rd_ptr_q, rd_ptr_d;
  logic [1:0]     count_q, count_d;
  logic           wr_en;
  logic           rd_en;
  tccu_pkg::req_t req_class;

  // Classify the incoming word.
  always_comb begin
    req_class.char_code = char_code_i;
    if (req_type_i == tccu_pkg::REQ_CLEAR) begin
      req_class.op = tccu_pkg::OP_CLEAR;
    end else begin
      unique case (char_code_i)
        tccu_pkg::CHAR_NEWLINE:   req_class.op = tccu_pkg::OP_NEWLINE;
        tccu_pkg::CHAR_BACKSPACE: req_class.op = tccu_pkg::OP_BACKSPACE;
        tccu_pkg::CHAR_TAB:       req_class.op = tccu_pkg::OP_TAB;
        tccu_pkg::CHAR_RETURN:    req_class.op = tccu_pkg::OP_RETURN;
        default:                  req_class.op = tccu_pkg::OP_PRINT;
      endcase
    end
  end

  // Queue pointers and fill count.
  assign full         = (count_q == 2'd2);
  assign head_valid_o = (count_q != 2'd0);
  assign head_o       = mem_q[rd_ptr_q];
  assign wr_en        = push && !full;
  assign rd_en        = head_pop_i && head_valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q ^ wr_en;
    rd_ptr_d = rd_ptr_q ^ rd_en;
    count_d  = count_q + 2'(wr_en) - 2'(rd_en);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Request storage.
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_ptr_q] <= req_class;
    end
  end

endmodule

### sv/tccu_back.sv
// ----------------------------------------------------------------------------
// Cursor engine back end
// Holds the pixel cursor and steps through the draw commands of the request
// at the head of the front queue, one command word per cycle unless stalled.
// ----------------------------------------------------------------------------
module tccu_back #(
  parameter int CELL_WIDTH        = 8,
  parameter int CELL_HEIGHT       = 8,
  parameter int SCREEN_PIX_WIDTH  = 1024,
  parameter int SCREEN_PIX_HEIGHT = 768
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              head_valid_i,
  input  tccu_pkg::req_t    head_i,
  output logic              head_pop_o,
  input  tccu_pkg::colour_t fg_colour_i,
  input  tccu_pkg::colour_t bg_colour_i,
  output logic              cmd_valid_o,
  output tccu_pkg::cmd_t    cmd_o,
  input  logic              cmd_ready_i
);

  localparam tccu_pkg::calc_t CellW   = tccu_pkg::calc_t'(CELL_WIDTH);
  localparam tccu_pkg::calc_t CellH   = tccu_pkg::calc_t'(CELL_HEIGHT);
  localparam tccu_pkg::calc_t ScrW    = tccu_pkg::calc_t'(SCREEN_PIX_WIDTH);
  localparam tccu_pkg::calc_t ScrH    = tccu_pkg::calc_t'(SCREEN_PIX_HEIGHT);
  localparam tccu_pkg::calc_t LastCol = tccu_pkg::calc_t'(SCREEN_PIX_WIDTH - CELL_WIDTH);

  tccu_pkg::pos_x_t cursor_x_q, cursor_x_d;
  tccu_pkg::pos_y_t cursor_y_q, cursor_y_d;
  tccu_pkg::step_t  step_q, step_d;
  logic [2:0]       rem5_q, rem5_d;

  tccu_pkg::calc_t  xw, yw;
  tccu_pkg::calc_t  x_right;
  tccu_pkg::calc_t  y_down, y_next_row;
  tccu_pkg::calc_t  x_print, x_tab;
  tccu_pkg::calc_t  nx, ny;
  tccu_pkg::colour_t print_colour;
  logic             fire;

  // Current cursor widened for the position arithmetic.
  always_comb begin
    xw         = tccu_pkg::calc_t'(cursor_x_q);
    yw         = tccu_pkg::calc_t'(cursor_y_q);
    x_right    = xw + CellW;
    y_down     = yw + CellH;
    y_next_row = (y_down >= ScrH) ? '0 : y_down;
    x_print    = xw + CellW;
    x_tab      = xw + tccu_pkg::calc_t'(3'd4 - rem5_q) * CellW;
  end

  // Cursor position after the request at the head of the queue.
  always_comb begin
    nx = xw;
    ny = yw;
    unique case (head_i.op)
      tccu_pkg::OP_CLEAR: begin
        nx = '0;
        ny = '0;
      end
      tccu_pkg::OP_NEWLINE: begin
        nx = '0;
        ny = y_next_row;
      end
      tccu_pkg::OP_BACKSPACE: begin
        if (xw >= CellW) begin
          nx = xw - CellW;
        end else if (yw >= CellH) begin
          nx = LastCol;
          ny = yw - CellH;
        end
      end
      tccu_pkg::OP_TAB: begin
        if (x_tab >= ScrW) begin
          nx = '0;
          ny = y_next_row;
        end else begin
          nx = x_tab;
        end
      end
      tccu_pkg::OP_RETURN: begin
        nx = '0;
      end
      tccu_pkg::OP_PRINT: begin
        if (x_print >= ScrW) begin
          nx = '0;
          ny = y_next_row;
        end else begin
          nx = x_print;
        end
      end
      default: begin
        nx = xw;
        ny = yw;
      end
    endcase
  end

  // Spaces print in the background colour, everything else in foreground.
  assign print_colour = (head_i.char_code == tccu_pkg::GLYPH_SPACE) ? bg_colour_i : fg_colour_i;

  // Command word for the current step.
  always_comb begin
    cmd_o.kind   = tccu_pkg::KIND_GLYPH;
    cmd_o.pos_x  = cursor_x_q;
    cmd_o.pos_y  = cursor_y_q;
    cmd_o.glyph  = tccu_pkg::GLYPH_ERASE;
    cmd_o.colour = bg_colour_i;
    cmd_o.last   = 1'b0;
    case (step_q)
      tccu_pkg::step_t'(0): begin
        if (head_i.op == tccu_pkg::OP_CLEAR) begin
          cmd_o.kind  = tccu_pkg::KIND_FILL;
          cmd_o.pos_x = '0;
          cmd_o.pos_y = '0;
          cmd_o.glyph = tccu_pkg::GLYPH_NONE;
          cmd_o.last  = 1'b1;
        end
      end
      tccu_pkg::step_t'(1): begin
        cmd_o.pos_x  = tccu_pkg::pos_x_t'(x_right);
        cmd_o.glyph  = tccu_pkg::GLYPH_CURSOR;
        cmd_o.colour = fg_colour_i;
        cmd_o.last   = (head_i.op == tccu_pkg::OP_RETURN);
      end
      tccu_pkg::step_t'(2): begin
        cmd_o.pos_x = tccu_pkg::pos_x_t'(x_right);
        if (head_i.op == tccu_pkg::OP_TAB) begin
          cmd_o.glyph = tccu_pkg::GLYPH_SPACE;
        end else if (head_i.op == tccu_pkg::OP_PRINT) begin
          cmd_o.pos_x  = cursor_x_q;
          cmd_o.glyph  = head_i.char_code;
          cmd_o.colour = print_colour;
        end
        cmd_o.last = (head_i.op == tccu_pkg::OP_NEWLINE) || (head_i.op == tccu_pkg::OP_PRINT);
      end
      tccu_pkg::step_t'(3): begin
        cmd_o.pos_x = tccu_pkg::pos_x_t'(nx);
        cmd_o.pos_y = tccu_pkg::pos_y_t'(ny);
        if (head_i.op == tccu_pkg::OP_TAB) begin
          cmd_o.glyph  = tccu_pkg::GLYPH_CURSOR;
          cmd_o.colour = fg_colour_i;
          cmd_o.last   = 1'b1;
        end else begin
          cmd_o.glyph = tccu_pkg::GLYPH_SPACE;
        end
      end
      default: begin
        cmd_o.pos_x  = tccu_pkg::pos_x_t'(nx);
        cmd_o.pos_y  = tccu_pkg::pos_y_t'(ny);
        cmd_o.glyph  = tccu_pkg::GLYPH_CURSOR;
        cmd_o.colour = fg_colour_i;
        cmd_o.last   = 1'b1;
      end
    endcase
  end

  // Issue one word per cycle while the result queue has room.
  assign cmd_valid_o = head_valid_i;
  assign fire        = head_valid_i && cmd_ready_i;
  assign head_pop_o  = fire && cmd_o.last;

  always_comb begin
    cursor_x_d = cursor_x_q;
    cursor_y_d = cursor_y_q;
    step_d     = step_q;
    rem5_d     = rem5_q;
    if (fire) begin
      if (step_q == '0) begin
        rem5_d = tccu_pkg::mod5_x(cursor_x_q);
      end
      if (cmd_o.last) begin
        cursor_x_d = tccu_pkg::pos_x_t'(nx);
        cursor_y_d = tccu_pkg::pos_y_t'(ny);
        step_d     = '0;
      end else begin
        step_d = step_q + tccu_pkg::step_t'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cursor_x_q <= '0;
      cursor_y_q <= '0;
      step_q     <= '0;
    end else begin
      cursor_x_q <= cursor_x_d;
      cursor_y_q <= cursor_y_d;
      step_q     <= step_d;
    end
  end

  // Column remainder, taken on the first command of each request.
  always_ff @(posedge clk_i) begin
    rem5_q <= rem5_d;
  end

endmodule

### sv/tccu_out_fifo.sv
// ----------------------------------------------------------------------------
// Cursor engine result queue
// Two-entry queue that separates the command sequencer from the consumer.
// ----------------------------------------------------------------------------
module tccu_out_fifo (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           wr_valid_i,
  input  tccu_pkg::cmd_t wr_data_i,
  output logic           wr_ready_o,
  output logic           empty,
  output tccu_pkg::cmd_t rd_data_o,
  input  logic           pop
);

  tccu_pkg::cmd_t mem_q [2];
  logic           wr_ptr_q, wr_ptr_d;
  logic           rd_ptr_q, rd_ptr_d;
  logic [1:0]     count_q, count_d;
  logic           wr_en;
  logic           rd_en;

  // Pointer and fill count update.
  assign wr_ready_o = (count_q != 2'd2);
  assign empty      = (count_q == 2'd0);
  assign rd_data_o  = mem_q[rd_ptr_q];
  assign wr_en      = wr_valid_i && wr_ready_o;
  assign rd_en      = pop && !empty;

  always_comb begin
    wr_ptr_d = wr_ptr_q ^ wr_en;
    rd_ptr_d = rd_ptr_q ^ rd_en;
    count_d  = count_q + 2'(wr_en) - 2'(rd_en);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Command word storage.
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_ptr_q] <= wr_data_i;
    end
  end

endmodule

### sv/tccu_checker.sv
// ----------------------------------------------------------------------------
// Cursor engine port checker
// Watches the top-level ports for command word ordering and accounting.
// ----------------------------------------------------------------------------
module tccu_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        push,
  input logic        full,
  input logic        empty,
  input logic        pop,
  input logic        cmd_kind_o,
  input logic [10:0] pos_x_o,
  input logic [9:0]  pos_y_o,
  input logic [7:0]  glyph_o,
  input logic        last_cmd_o
);

  logic       start_q;
  logic [2:0] pending_q;
  logic       in_acc;
  logic       out_acc;
  logic       done_acc;

  assign in_acc   = push && !full;
  assign out_acc  = pop && !empty;
  assign done_acc = out_acc && last_cmd_o;

  // Tracks whether the next word opens a request, and how many requests
  // are accepted but not finished.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_q   <= 1'b1;
      pending_q <= 3'd0;
    end else begin
      if (out_acc) begin
        start_q <= last_cmd_o;
      end
      pending_q <= pending_q + 3'(in_acc) - 3'(done_acc);
    end
  end

  // Both queues come out of reset empty.
  assert property (@(posedge clk_i) $rose(rst_ni) |-> (empty && !full))
    else $error("queues not empty after reset");

  // A fill command is a complete request of its own at the origin.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && cmd_kind_o) |-> (last_cmd_o && pos_x_o == '0 && pos_y_o == '0 && glyph_o == '0))
    else $error("malformed fill command");

  // Each request opens with a fill or with the cursor erase.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && start_q) |-> (cmd_kind_o || glyph_o == 8'd8))
    else $error("request does not open with fill or erase");

  // No word is shown without an unfinished request behind it.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty |-> (pending_q != 3'd0))
    else $error("result word without an accepted request");

endmodule

bind text_console_cursor_engine_unit tccu_checker u_tccu_checker (.*);
